// ----- design/efh_pkg.sv -----
`timescale 1ns / 1ps
// efh_pkg: beat types, hash constants and helpers for the ecmp flow hash unit
// no dependencies; imported by every efh module
package efh_pkg;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [4:0]  next_hop_count;
  } efh_req_t;

  typedef struct packed {
    logic        route_found;
    logic [3:0]  next_hop_slot;
    logic [31:0] flow_hash;
  } efh_rsp_t;

  // three 32-bit key words: source, destination, port word
  typedef logic [2:0][31:0] efh_key_t;
  typedef logic [4:0]       efh_cnt_t;

  localparam logic [31:0] MmC1 = 32'hcc9e2d51;
  localparam logic [31:0] MmC2 = 32'h1b873593;
  localparam logic [31:0] MmN  = 32'he6546b64;
  localparam logic [31:0] MmF1 = 32'h85ebca6b;
  localparam logic [31:0] MmF2 = 32'hc2b2ae35;
  localparam logic [31:0] KeyBytes = 32'd12;

  localparam logic [7:0] ProtoTcp  = 8'h06;
  localparam logic [7:0] ProtoUdp  = 8'h11;
  localparam logic [7:0] ProtoAck  = 8'hFC;
  localparam logic [7:0] ProtoNack = 8'hFD;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ----- design/efh_block_mul.sv -----
`timescale 1ns / 1ps
// efh_block_mul: two-stage per-word block scramble (k*c1, rotl 15, *c2)
// depends on efh_pkg
module efh_block_mul
  import efh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  efh_key_t key,
  input  efh_cnt_t cnt,
  output logic     out_valid,
  input  logic     out_ready,
  output efh_key_t blk,
  output efh_cnt_t cnt_out
);

  logic     v1, v2;
  logic     en1, en2;
  efh_key_t m1, m2;
  efh_cnt_t c1, c2;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // independent lanes, one multiply per register stage
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      for (int i = 0; i < 3; i++) m1[i] <= key[i] * MmC1;
      c1 <= cnt;
    end
    if (en2 && v1) begin
      for (int i = 0; i < 3; i++) m2[i] <= rotl32(m1[i], 15) * MmC2;
      c2 <= c1;
    end
  end

  assign out_valid = v2;
  assign blk       = m2;
  assign cnt_out   = c2;

endmodule

// ----- design/efh_hash_chain.sv -----
`timescale 1ns / 1ps
// efh_hash_chain: five-stage unit, a seed chain over three blocks plus the finalizer multiplies
// depends on efh_pkg
module efh_hash_chain
  import efh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  efh_key_t    blk,
  input  efh_cnt_t    cnt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pre_hash,
  output efh_cnt_t    cnt_out
);

  function automatic logic [31:0] mix_step(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] x;
    x = rotl32(h ^ k, 13);
    return x + (x << 2) + MmN;
  endfunction

  logic [4:0]  v;
  logic [4:0]  en;
  logic [31:0] h0, h1, h2, x3, x4;
  logic [31:0] k1_0, k2_0, k2_1;
  efh_cnt_t    c0, c1, c2, c3, c4;
  logic [31:0] t3, t4;

  always_comb begin
    en[4] = !v[4] || out_ready;
    for (int i = 3; i >= 0; i--) en[i] = !v[i] || en[i + 1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < 5; i++) begin
        if (en[i]) v[i] <= v[i - 1];
      end
    end
  end

  always_comb begin
    t3 = h2 ^ KeyBytes;
    t3 = t3 ^ (t3 >> 16);
    t4 = x3 ^ (x3 >> 13);
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      h0   <= mix_step(seed, blk[0]);
      k1_0 <= blk[1];
      k2_0 <= blk[2];
      c0   <= cnt;
    end
    if (en[1] && v[0]) begin
      h1   <= mix_step(h0, k1_0);
      k2_1 <= k2_0;
      c1   <= c0;
    end
    if (en[2] && v[1]) begin
      h2 <= mix_step(h1, k2_1);
      c2 <= c1;
    end
    if (en[3] && v[2]) begin
      x3 <= t3 * MmF1;
      c3 <= c2;
    end
    if (en[4] && v[3]) begin
      x4 <= t4 * MmF2;
      c4 <= c3;
    end
  end

  assign out_valid = v[4];
  assign pre_hash  = x4;
  assign cnt_out   = c4;

endmodule

// ----- design/efh_mod_unit.sv -----
`timescale 1ns / 1ps
// efh_mod_unit: last finalizer xor and a four-stage restoring remainder, 8 bits a stage
// depends on efh_pkg
module efh_mod_unit
  import efh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pre_hash,
  input  efh_cnt_t    cnt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash,
  output efh_cnt_t    rem,
  output efh_cnt_t    cnt_out
);

  localparam int Stages = 4;
  localparam int BitsPerStage = 32 / Stages;

  // partial remainder stays below a nonzero divisor, so {r, bit} fits six bits
  function automatic efh_cnt_t rem_step(input efh_cnt_t r, input logic b, input efh_cnt_t d);
    logic [5:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[4:0];
  endfunction

  logic [Stages-1:0] v;
  logic [Stages-1:0] en;
  logic [31:0]       h_q   [Stages];
  efh_cnt_t          r_q   [Stages];
  efh_cnt_t          d_q   [Stages];
  logic [31:0]       h_src [Stages];
  efh_cnt_t          d_src [Stages];
  efh_cnt_t          r_nxt [Stages];
  logic [Stages-1:0] v_src;

  always_comb begin
    en[Stages-1] = !v[Stages-1] || out_ready;
    for (int i = Stages - 2; i >= 0; i--) en[i] = !v[i] || en[i + 1];
  end
  assign in_ready = en[0];

  always_comb begin
    for (int s = 0; s < Stages; s++) begin
      if (s == 0) begin
        h_src[s] = pre_hash ^ (pre_hash >> 16);
        d_src[s] = cnt;
        r_nxt[s] = '0;
        v_src[s] = in_valid;
      end else begin
        h_src[s] = h_q[s - 1];
        d_src[s] = d_q[s - 1];
        r_nxt[s] = r_q[s - 1];
        v_src[s] = v[s - 1];
      end
      for (int j = 0; j < BitsPerStage; j++) begin
        r_nxt[s] = rem_step(r_nxt[s], h_src[s][5'(31 - BitsPerStage * s - j)], d_src[s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < Stages; s++) begin
        if (en[s]) v[s] <= v_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < Stages; s++) begin
      if (en[s] && v_src[s]) begin
        h_q[s] <= h_src[s];
        d_q[s] <= d_src[s];
        r_q[s] <= r_nxt[s];
      end
    end
  end

  assign out_valid = v[Stages-1];
  assign hash      = h_q[Stages-1];
  assign rem       = r_q[Stages-1];
  assign cnt_out   = d_q[Stages-1];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cnt_out != '0) |-> rem < cnt_out)
    else $error("remainder not below divisor");

endmodule

// ----- design/ecmp_flow_hash_next_hop_unit.sv -----
`timescale 1ns / 1ps
// ecmp_flow_hash_next_hop_unit: murmur3 x86_32 flow hash over a 12-byte key, slot = hash mod count
// pipeline from req beat to rsp beat: 2 block multiply, 5 hash chain and 4 remainder stages
// throughput one beat per cycle unless the rsp side stalls; every stage holds its beat while the rsp side stalls
// synchronous active-high rst clears all stage valid bits and the hash seed to zero
// depends on efh_pkg, efh_block_mul, efh_hash_chain, efh_mod_unit
module ecmp_flow_hash_next_hop_unit
  import efh_pkg::*;
#(
  parameter int MAX_NEXT_HOPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  efh_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output efh_rsp_t    rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // seed register; the user must write it only while the pipe is drained, the block does not enforce this
  logic [31:0] seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  // key build: port word only for tcp, udp and ack/nack, zero otherwise
  efh_key_t key;
  efh_cnt_t cnt_sat;
  logic     ports_used;

  always_comb begin
    ports_used = req.protocol inside {ProtoTcp, ProtoUdp, ProtoAck, ProtoNack};
    key[0] = req.source_address;
    key[1] = req.destination_address;
    key[2] = ports_used ? {req.destination_port, req.source_port} : '0;
    // counts beyond the table size clamp to the table size
    if (int'(req.next_hop_count) > MAX_NEXT_HOPS) begin
      cnt_sat = 5'(MAX_NEXT_HOPS);
    end else begin
      cnt_sat = req.next_hop_count;
    end
  end

  // block scramble stages
  logic     bm_valid, bm_ready;
  efh_key_t bm_blk;
  efh_cnt_t bm_cnt;

  efh_block_mul u_block_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .key       (key),
    .cnt       (cnt_sat),
    .out_valid (bm_valid),
    .out_ready (bm_ready),
    .blk       (bm_blk),
    .cnt_out   (bm_cnt)
  );

  // seed chain and finalizer multiplies
  logic        hc_valid, hc_ready;
  logic [31:0] hc_pre;
  efh_cnt_t    hc_cnt;

  efh_hash_chain u_hash_chain (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .in_valid  (bm_valid),
    .in_ready  (bm_ready),
    .blk       (bm_blk),
    .cnt       (bm_cnt),
    .out_valid (hc_valid),
    .out_ready (hc_ready),
    .pre_hash  (hc_pre),
    .cnt_out   (hc_cnt)
  );

  // final xor plus remainder; its last stage is the rsp output register
  logic [31:0] mu_hash;
  efh_cnt_t    mu_rem, mu_cnt;

  efh_mod_unit u_mod_unit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hc_valid),
    .in_ready  (hc_ready),
    .pre_hash  (hc_pre),
    .cnt       (hc_cnt),
    .out_valid (rsp_valid),
    .out_ready (rsp_ready),
    .hash      (mu_hash),
    .rem       (mu_rem),
    .cnt_out   (mu_cnt)
  );

  // no route: slot forced to zero, hash still reported
  always_comb begin
    rsp.route_found   = (mu_cnt != '0);
    rsp.next_hop_slot = rsp.route_found ? mu_rem[3:0] : '0;
    rsp.flow_hash     = mu_hash;
  end

  // back-pressure reaches the req side only when every stage holds a beat
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("req stalled with room in the pipe");

  a_slot_in_table: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.route_found |-> int'(rsp.next_hop_slot) < MAX_NEXT_HOPS)
    else $error("slot outside next hop table");

  // a stalled rsp beat stays up and unchanged
  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

endmodule
